[src/conv2d_3x3_zero_pad_macros.svh]
// Assertion macros shared by the convolution block.
`ifndef CONV2D_3X3_ZERO_PAD_MACROS_SVH
`define CONV2D_3X3_ZERO_PAD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define C2D_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define C2D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/c2d_pkg.sv]
// Shared types and constants of the 3x3 convolution block.
`timescale 1ns / 1ps

package c2d_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int PIX_W      = 8;
	localparam int ROW_W      = 12;
	localparam int QROW_W     = ROW_W + 1;
	localparam int KERN_W     = 24;
	localparam int FW_W       = 11;
	localparam int FH_W       = 12;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam logic [PIX_W-1:0]  OUT_BIAS         = 8'd127;
	localparam logic [KERN_W-1:0] KERN_TOP_RST     = 24'd0;
	localparam logic [KERN_W-1:0] KERN_MIDDLE_RST  = 24'd256;
	localparam logic [KERN_W-1:0] KERN_BOTTOM_RST  = 24'd0;
	localparam logic [FW_W-1:0]   FRAME_WIDTH_RST  = 11'd640;
	localparam logic [FH_W-1:0]   FRAME_HEIGHT_RST = 12'd480;

	typedef enum logic {
		OP_PIXEL = 1'b0,
		OP_DRAIN = 1'b1
	} c2d_op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_TOP    = 3'd0,
		REG_KERNEL_MIDDLE = 3'd1,
		REG_KERNEL_BOTTOM = 3'd2,
		REG_FRAME_WIDTH   = 3'd3,
		REG_FRAME_HEIGHT  = 3'd4
	} c2d_reg_t;

	// One window column: element 0 is the top pixel, element 2 the bottom one.
	typedef logic [2:0][PIX_W-1:0] c2d_col_t;

	// Which window edges fall outside the frame for one output pixel.
	typedef struct packed {
		logic top;
		logic bottom;
		logic left;
		logic right;
	} c2d_mask_t;

	typedef struct packed {
		logic shift;
		logic capture;
		logic top_off;
		logic bottom_off;
		logic col_off;
	} c2d_cell_ctl_t;

endpackage

[src/conv2d_3x3_zero_pad.sv]
// Top level of the streaming 3x3 convolution with zero padding.
`timescale 1ns / 1ps
`include "conv2d_3x3_zero_pad_macros.svh"

// Streaming 3x3 convolution of 8-bit grayscale pixels in raster order. Each input transfer
// carries one pixel (tuser low) or one drain step (tuser high); each output transfer carries
// the flipped-kernel sum over the pixel's 3x3 neighborhood plus 127, low 8 bits, with tlast on
// the last pixel of the frame. Neighbors outside the frame count as zero. The block takes one
// transfer per clock while its skid stage is empty. Pipeline stages: line store read, window
// shift, products, sum. Three column cells shift the window by one column per item, and three
// single-port-write line stores feed them, so the rate is set by the one write per store per
// clock. Output k of a frame leaves on the item that brings the pixel one row and one column
// past it, so after the last pixel the source sends frame_width + 1 drain steps. Drain steps
// before the last pixel are consumed with no effect, and pixels after the last pixel act as
// drain steps. Frame width and height are taken at the first pixel of a frame (width 0 counts
// as 1 and is capped at the line store depth, height 0 counts as 1); kernel writes act at once.
// The line stores are not cleared after reset: entries are only used once written in the frame.
module conv2d_3x3_zero_pad (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_write,
	input  logic [c2d_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [c2d_pkg::CFG_DATA_W-1:0] cfg_data,
	// Input stream.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [c2d_pkg::PIX_W-1:0]      s_axis_tdata,  // [7:0] pixel_value
	input  logic                           s_axis_tuser,  // [0] operation
	// Output stream.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [c2d_pkg::PIX_W-1:0]      m_axis_tdata,  // [7:0] out_pixel
	output logic                           m_axis_tlast
);
	import c2d_pkg::*;

	// Configuration registers.
	logic [KERN_W-1:0] kern_q [3];
	logic [FW_W-1:0]   fw_q;
	logic [FH_W-1:0]   fh_q;

	// Frame control.
	logic              started_q;
	logic              complete_q;
	logic [COL_W-1:0]  qc_q;
	logic [QROW_W-1:0] qr_q;
	logic [1:0]        qmod_q;
	logic [COL_W-1:0]  oc_q;
	logic [ROW_W-1:0]  or_q;
	logic [COL_W-1:0]  lat_w_m1_q;
	logic [ROW_W-1:0]  lat_h_m1_q;

	logic [COL_W-1:0]  w_cfg_m1;
	logic [ROW_W-1:0]  h_cfg_m1;
	logic [COL_W-1:0]  w_m1;
	logic [ROW_W-1:0]  h_m1;
	logic [QROW_W-1:0] h_m1_ext;
	logic [QROW_W-1:0] lat_h_ext;
	logic              en;
	logic              accept;
	logic              is_pixel;
	logic              step;
	logic              pix_write;
	logic              emit_now;
	logic              o_last;
	logic              frame_done;
	logic              qc_last;
	c2d_mask_t         mask_now;

	// Pipeline.
	logic              valid_s1;
	logic              emit_s1;
	logic              emit_s2;
	logic              emit_s3;
	logic              last_s1;
	logic              last_s2;
	logic              last_s3;
	c2d_mask_t         mask_s1;
	c2d_mask_t         mask_s2;
	logic [PIX_W-1:0]  pix_s1;
	logic [1:0]        qmod_s1;
	logic [PIX_W-1:0]  rd_data [3];
	c2d_col_t          new_col;
	c2d_col_t          win_col [3];
	logic [PIX_W-1:0]  cell_sum [3];
	logic [PIX_W-1:0]  result;

	// Output register and skid stage.
	logic              out_valid_q;
	logic [PIX_W-1:0]  out_data_q;
	logic              out_last_q;
	logic              skid_valid_q;
	logic [PIX_W-1:0]  skid_data_q;
	logic              skid_last_q;
	logic              push;
	logic              pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kern_q[0] <= KERN_TOP_RST;
			kern_q[1] <= KERN_MIDDLE_RST;
			kern_q[2] <= KERN_BOTTOM_RST;
			fw_q      <= FRAME_WIDTH_RST;
			fh_q      <= FRAME_HEIGHT_RST;
		end else if (cfg_write) begin
			case (c2d_reg_t'(cfg_index))
				REG_KERNEL_TOP:    kern_q[0] <= cfg_data[KERN_W-1:0];
				REG_KERNEL_MIDDLE: kern_q[1] <= cfg_data[KERN_W-1:0];
				REG_KERNEL_BOTTOM: kern_q[2] <= cfg_data[KERN_W-1:0];
				REG_FRAME_WIDTH:   fw_q      <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT:  fh_q      <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// Geometry as it will be latched by the first pixel of a frame.
	always_comb begin
		if (fw_q == '0) begin
			w_cfg_m1 = '0;
		end else if (int'(fw_q) > MAX_WIDTH) begin
			w_cfg_m1 = COL_W'(MAX_WIDTH - 1);
		end else begin
			w_cfg_m1 = COL_W'(fw_q - 1'b1);
		end
		h_cfg_m1 = (fh_q == '0) ? '0 : ROW_W'(fh_q - 1'b1);
	end

	assign w_m1      = started_q ? lat_w_m1_q : w_cfg_m1;
	assign h_m1      = started_q ? lat_h_m1_q : h_cfg_m1;
	assign h_m1_ext  = QROW_W'(h_m1);
	assign lat_h_ext = QROW_W'(lat_h_m1_q);

	assign en            = !skid_valid_q;
	assign s_axis_tready = en;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_pixel      = c2d_op_t'(s_axis_tuser) == OP_PIXEL;
	// After the last pixel every transfer counts as a drain step.
	assign step          = accept && (is_pixel || complete_q);
	assign pix_write     = accept && is_pixel && !complete_q;
	assign qc_last       = qc_q == w_m1;

	// The incoming position sits one row and one column past the next output, so
	// outputs begin once it reaches the second pixel of the second row.
	assign emit_now   = (qr_q >= QROW_W'(2)) || ((qr_q == QROW_W'(1)) && (qc_q != '0));
	assign o_last     = (or_q == h_m1) && (oc_q == w_m1);
	assign frame_done = step && emit_now && o_last;

	always_comb begin
		mask_now.top    = or_q == '0;
		mask_now.bottom = or_q == h_m1;
		mask_now.left   = oc_q == '0;
		mask_now.right  = oc_q == w_m1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q  <= 1'b0;
			complete_q <= 1'b0;
			qc_q       <= '0;
			qr_q       <= '0;
			qmod_q     <= '0;
			oc_q       <= '0;
			or_q       <= '0;
			lat_w_m1_q <= COL_W'(int'(FRAME_WIDTH_RST) - 1);
			lat_h_m1_q <= ROW_W'(int'(FRAME_HEIGHT_RST) - 1);
		end else if (step) begin
			if (!started_q) begin
				lat_w_m1_q <= w_cfg_m1;
				lat_h_m1_q <= h_cfg_m1;
			end
			if (frame_done) begin
				started_q  <= 1'b0;
				complete_q <= 1'b0;
				qc_q       <= '0;
				qr_q       <= '0;
				qmod_q     <= '0;
				oc_q       <= '0;
				or_q       <= '0;
			end else begin
				started_q <= 1'b1;
				if (qc_last) begin
					qc_q   <= '0;
					qr_q   <= qr_q + 1'b1;
					qmod_q <= (qmod_q == 2'd2) ? 2'd0 : qmod_q + 1'b1;
					if (pix_write && qr_q == h_m1_ext) begin
						complete_q <= 1'b1;
					end
				end else begin
					qc_q <= qc_q + 1'b1;
				end
				if (emit_now) begin
					if (oc_q == w_m1) begin
						oc_q <= '0;
						or_q <= or_q + 1'b1;
					end else begin
						oc_q <= oc_q + 1'b1;
					end
				end
			end
		end
	end

	// Three row stores used in rotation: the row being received is written while the
	// two rows above it are read at the same column.
	for (genvar g = 0; g < 3; g++) begin : g_store
		c2d_line_store u_store (
			.clk     (clk),
			.wr_en   (pix_write && qmod_q == 2'(g)),
			.wr_addr (qc_q),
			.wr_data (s_axis_tdata),
			.rd_en   (step),
			.rd_addr (qc_q),
			.rd_data (rd_data[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			emit_s1  <= 1'b0;
			emit_s2  <= 1'b0;
			emit_s3  <= 1'b0;
		end else if (en) begin
			valid_s1 <= step;
			emit_s1  <= step && emit_now;
			emit_s2  <= emit_s1;
			emit_s3  <= emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mask_s1 <= mask_now;
			last_s1 <= o_last;
			pix_s1  <= s_axis_tdata;
			qmod_s1 <= qmod_q;
			mask_s2 <= mask_s1;
			last_s2 <= last_s1;
			last_s3 <= last_s2;
		end
	end

	always_comb begin
		new_col[2] = pix_s1;
		case (qmod_s1)
			2'd0: begin
				new_col[0] = rd_data[1];
				new_col[1] = rd_data[2];
			end
			2'd1: begin
				new_col[0] = rd_data[2];
				new_col[1] = rd_data[0];
			end
			default: begin
				new_col[0] = rd_data[0];
				new_col[1] = rd_data[1];
			end
		endcase
	end

	// Cell 2 holds the newest column; the kernel is flipped, so cell j uses
	// kernel column 2 - j and its top pixel uses kernel row 2.
	for (genvar j = 0; j < 3; j++) begin : g_cell
		c2d_col_t      cell_coef;
		c2d_cell_ctl_t cell_ctl;

		for (genvar i = 0; i < 3; i++) begin : g_coef
			assign cell_coef[i] = kern_q[2 - i][PIX_W * (2 - j) +: PIX_W];
		end

		always_comb begin
			cell_ctl.shift      = en && valid_s1;
			cell_ctl.capture    = en;
			cell_ctl.top_off    = mask_s2.top;
			cell_ctl.bottom_off = mask_s2.bottom;
			if (j == 0) begin
				cell_ctl.col_off = mask_s2.left;
			end else if (j == 2) begin
				cell_ctl.col_off = mask_s2.right;
			end else begin
				cell_ctl.col_off = 1'b0;
			end
		end

		c2d_column_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl),
			.col_in  ((j == 2) ? new_col : win_col[(j == 2) ? j : j + 1]),
			.coef    (cell_coef),
			.col_out (win_col[j]),
			.sum_out (cell_sum[j])
		);
	end

	assign result = cell_sum[0] + cell_sum[1] + cell_sum[2] + OUT_BIAS;

	assign push = en && emit_s3;
	assign pop  = out_valid_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
				out_last_q <= skid_last_q;
			end else begin
				out_data_q <= result;
				out_last_q <= last_s3;
			end
		end else if (push) begin
			skid_data_q <= result;
			skid_last_q <= last_s3;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	`C2D_ASSERT_HOLDS(a_skid_needs_main, skid_valid_q, out_valid_q, "skid stage full while output register empty")
	`C2D_ASSERT_HOLDS(a_skid_cause, $rose(skid_valid_q), $past(out_valid_q && !m_axis_tready), "skid stage filled without a stalled output")
	`C2D_ASSERT_NEXT(a_frame_restart, frame_done, !started_q && !complete_q, "frame state not cleared after last output")
	`C2D_ASSERT_HOLDS(a_complete_past_rows, complete_q, qr_q > lat_h_ext, "frame marked complete before all rows arrived")
	`C2D_ASSERT_HOLDS(a_emit_in_frame, step && emit_now, started_q, "output produced on the first step of a frame")

endmodule

[src/c2d_line_store.sv]
// One row of pixel storage with a registered read port.
`timescale 1ns / 1ps

module c2d_line_store (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [c2d_pkg::COL_W-1:0] wr_addr,
	input  logic [c2d_pkg::PIX_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [c2d_pkg::COL_W-1:0] rd_addr,
	output logic [c2d_pkg::PIX_W-1:0] rd_data
);
	import c2d_pkg::*;

	logic [PIX_W-1:0] mem_q [MAX_WIDTH];
	logic [PIX_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[src/c2d_column_cell.sv]
// Window column cell: holds one pixel column, passes it on and forms its weighted sum.
`timescale 1ns / 1ps

module c2d_column_cell (
	input  logic                      clk,
	input  c2d_pkg::c2d_cell_ctl_t    ctl,
	input  c2d_pkg::c2d_col_t         col_in,
	input  c2d_pkg::c2d_col_t         coef,
	output c2d_pkg::c2d_col_t         col_out,
	output logic [c2d_pkg::PIX_W-1:0] sum_out
);
	import c2d_pkg::*;

	c2d_col_t         col_q;
	logic [PIX_W-1:0] sum_q;
	logic [PIX_W-1:0] sum_d;

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			col_q <= col_in;
		end
	end

	// Only the low byte of the total is kept, so each product is needed
	// only modulo 256 and an 8x8 multiply with an 8-bit result suffices.
	always_comb begin
		logic [PIX_W-1:0] term;
		logic             off;
		sum_d = '0;
		for (int i = 0; i < 3; i++) begin
			off  = ctl.col_off || (i == 0 && ctl.top_off) || (i == 2 && ctl.bottom_off);
			term = PIX_W'(col_q[i] * coef[i]);
			sum_d = sum_d + (off ? '0 : term);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			sum_q <= sum_d;
		end
	end

	assign col_out = col_q;
	assign sum_out = sum_q;

endmodule

[verif/conv2d_3x3_zero_pad_tb.sv]
// Self-checking testbench for the streaming 3x3 zero-padded convolution block.
`timescale 1ns / 1ps

module conv2d_3x3_zero_pad_tb;
	import c2d_pkg::*;

	localparam int LAT_WAIT       = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_ITEMS    = 310;
	localparam int REPORT_LIMIT   = 10;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_end;
	} conv_result_t;

	typedef enum logic [1:0] {
		ROW_WRITE,
		ROW_ITEM,
		ROW_CHECK
	} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		c2d_reg_t               idx;
		logic [CFG_DATA_W-1:0]  val;
		c2d_op_t                op;
		logic [PIX_W-1:0]       pix;
		logic [PIX_W-1:0]       exp_pix;
		logic                   exp_end;
	} plan_row_t;

	// Identity kernel out of reset on a 2x1 frame, then a 1x1 frame with extreme coefficients,
	// then a 3x3 frame with an asymmetric kernel that exposes the kernel flip.
	localparam plan_row_t DIRECTED_PLAN [34] = '{
		'{ROW_WRITE, REG_FRAME_WIDTH,   24'd2,       OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_WRITE, REG_FRAME_HEIGHT,  24'd1,       OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_DRAIN, 8'h5A, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'hFF, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_DRAIN, 8'h00, 8'h00, 1'b0},
		'{ROW_CHECK, REG_KERNEL_TOP,    24'd0,       OP_DRAIN, 8'h00, 8'd127, 1'b0},
		'{ROW_CHECK, REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'hAA, 8'd126, 1'b1},
		'{ROW_WRITE, REG_KERNEL_TOP,    24'h808080,  OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_WRITE, REG_KERNEL_MIDDLE, 24'h007F00,  OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_WRITE, REG_KERNEL_BOTTOM, 24'hFFFFFF,  OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_WRITE, REG_FRAME_WIDTH,   24'd0,       OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_WRITE, REG_FRAME_HEIGHT,  24'd0,       OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'hFF, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_DRAIN, 8'hFF, 8'h00, 1'b0},
		'{ROW_CHECK, REG_KERNEL_TOP,    24'd0,       OP_DRAIN, 8'h00, 8'd0,   1'b1},
		'{ROW_WRITE, REG_KERNEL_TOP,    24'h7F7F7F,  OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_WRITE, REG_KERNEL_MIDDLE, 24'h807F80,  OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_WRITE, REG_KERNEL_BOTTOM, 24'h01FF80,  OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_WRITE, REG_FRAME_WIDTH,   24'd3,       OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_WRITE, REG_FRAME_HEIGHT,  24'd3,       OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'hFF, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'h80, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'h7F, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'hFF, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'h00, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'h01, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'hFE, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_PIXEL, 8'hFF, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_DRAIN, 8'h00, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_DRAIN, 8'hFF, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_DRAIN, 8'h00, 8'h00, 1'b0},
		'{ROW_ITEM,  REG_KERNEL_TOP,    24'd0,       OP_DRAIN, 8'h00, 8'h00, 1'b0}
	};

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_write     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [PIX_W-1:0]      s_axis_tdata  = '0;
	logic                  s_axis_tuser  = 1'b0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [PIX_W-1:0]      m_axis_tdata;
	logic                  m_axis_tlast;

	// Shadow of the block's registers and of its frame state.
	logic [KERN_W-1:0] kern_rows [3];
	logic [FW_W-1:0]   width_reg;
	logic [FH_W-1:0]   height_reg;
	logic [PIX_W-1:0]  line_mem [3][MAX_WIDTH];
	int                frame_w, frame_h;
	int                in_col, in_row, out_col, out_row;
	int                frame_steps;
	bit                frame_received;

	conv_result_t pending_pixels [$];
	conv_result_t head;
	int           send_idle_pct  = 0;
	int           recv_stall_pct = 0;
	int           steps_taken    = 0;
	int           error_count    = 0;
	int           idle_cycles    = 0;

	conv2d_3x3_zero_pad dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #5 clk = ~clk;

	function automatic int geom_width(input logic [FW_W-1:0] w);
		if (w == 0)
			return 1;
		return (w > MAX_WIDTH) ? MAX_WIDTH : int'(w);
	endfunction

	function automatic int geom_height(input logic [FH_W-1:0] h);
		return (h == 0) ? 1 : int'(h);
	endfunction

	// Returns -1 when the step is ignored, 0 when it gives no pixel, 1 when it gives one.
	function automatic int convolve_step(input c2d_op_t op, input logic [PIX_W-1:0] pix,
			output conv_result_t res);
		int  k, sum, r, c, p, cur_row, cur_col, status;
		bit  have_cur;
		have_cur = 1'b0;
		cur_row  = 0;
		cur_col  = 0;
		status   = 0;
		res      = '0;
		if (op == OP_PIXEL && !frame_received) begin
			if (frame_steps == 0) begin
				frame_w = geom_width(width_reg);
				frame_h = geom_height(height_reg);
			end
			have_cur = 1'b1;
			cur_row  = in_row;
			cur_col  = in_col;
			frame_steps++;
			if (in_col + 1 >= frame_w) begin
				in_col = 0;
				in_row++;
				if (in_row >= frame_h)
					frame_received = 1'b1;
			end else begin
				in_col++;
			end
		end else if (frame_received) begin
			frame_steps++;
		end else begin
			return -1;
		end
		k = out_row * frame_w + out_col;
		if (frame_steps >= k + frame_w + 2) begin
			sum = 0;
			for (int dr = -1; dr <= 1; dr++) begin
				for (int dc = -1; dc <= 1; dc++) begin
					r = out_row + dr;
					c = out_col + dc;
					if (r >= 0 && c >= 0 && r < frame_h && c < frame_w) begin
						// The pixel of this very step is not in the line store yet.
						if (have_cur && r == cur_row && c == cur_col)
							p = pix;
						else
							p = line_mem[r % 3][c];
						sum += p * $signed(kern_rows[1 - dr][8 * (1 - dc) +: 8]);
					end
				end
			end
			res.pixel     = PIX_W'(sum + int'(OUT_BIAS));
			res.frame_end = (k + 1 >= frame_w * frame_h);
			status        = 1;
			if (out_col + 1 >= frame_w) begin
				out_col = 0;
				out_row++;
			end else begin
				out_col++;
			end
			if (res.frame_end) begin
				in_col         = 0;
				in_row         = 0;
				out_col        = 0;
				out_row        = 0;
				frame_steps    = 0;
				frame_received = 1'b0;
			end
		end
		if (have_cur)
			line_mem[cur_row % 3][cur_col] = pix;
		return status;
	endfunction

	function automatic logic [PIX_W-1:0] rand_pixel();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10)
			return '0;
		if (pick < 20)
			return '1;
		return PIX_W'($urandom);
	endfunction

	function automatic logic [KERN_W-1:0] rand_kernel_row();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return 24'h808080;
		if (pick < 10)
			return 24'h7F7F7F;
		if (pick < 15)
			return '0;
		return KERN_W'($urandom);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_width();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			return '0;
		if (pick < 12)
			return CFG_DATA_W'($urandom_range(40, 9));
		return CFG_DATA_W'($urandom_range(8, 1));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_height();
		if ($urandom_range(99) < 5)
			return '0;
		return CFG_DATA_W'($urandom_range(6, 1));
	endfunction

	task automatic report_mismatch(input string what, input conv_result_t want);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("%0t %0s: expected pixel %0d end %0d, got pixel %0d end %0d",
				$realtime, what, want.pixel, want.frame_end, m_axis_tdata, m_axis_tlast);
	endtask

	// Lets every outstanding pixel leave, then gives the pipeline time to settle.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (LAT_WAIT) @(posedge clk);
	endtask

	// Leaves cfg_write high; the next item transfer lowers it.
	task automatic reg_write(input c2d_reg_t idx, input logic [CFG_DATA_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		case (idx)
			REG_KERNEL_TOP, REG_KERNEL_MIDDLE, REG_KERNEL_BOTTOM: kern_rows[idx] = val;
			REG_FRAME_WIDTH:  width_reg  = val[FW_W-1:0];
			REG_FRAME_HEIGHT: height_reg = val[FH_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_item(input c2d_op_t op, input logic [PIX_W-1:0] pix, input bit typed,
			input conv_result_t typed_res);
		int           gap, status;
		conv_result_t res;
		cfg_write <= 1'b0;
		gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(3, 1) : 0;
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= pix;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		status = convolve_step(op, pix, res);
		if (typed)
			pending_pixels.push_back(typed_res);
		else if (status == 1)
			pending_pixels.push_back(res);
		if (status >= 0)
			steps_taken++;
	endtask

	// One frame: all pixels, then width + 1 flush steps, some of them extra pixels.
	task automatic image_frame(input bit noisy);
		int w, h;
		w = geom_width(width_reg);
		h = geom_height(height_reg);
		for (int i = 0; i < w * h; i++) begin
			if (noisy && $urandom_range(99) < 8)
				send_item(OP_DRAIN, rand_pixel(), 1'b0, '0);
			send_item(OP_PIXEL, rand_pixel(), 1'b0, '0);
			// A geometry write after the first pixel must only affect the next frame.
			if (i == 0 && $urandom_range(99) < 10) begin
				wait_idle();
				reg_write(REG_FRAME_WIDTH, pick_width());
				reg_write(REG_FRAME_HEIGHT, pick_height());
			end
		end
		for (int i = 0; i <= w; i++) begin
			if ($urandom_range(99) < 30)
				send_item(OP_PIXEL, rand_pixel(), 1'b0, '0);
			else
				send_item(OP_DRAIN, rand_pixel(), 1'b0, '0);
		end
		if (noisy)
			repeat ($urandom_range(2)) send_item(OP_DRAIN, rand_pixel(), 1'b0, '0);
	endtask

	task automatic retune_between_frames();
		bit geom, kern;
		geom = ($urandom_range(99) < 60) ||
			(geom_width(width_reg) * geom_height(height_reg) > 100);
		kern = ($urandom_range(99) < 50);
		if (geom || kern)
			wait_idle();
		if (geom) begin
			reg_write(REG_FRAME_WIDTH, pick_width());
			reg_write(REG_FRAME_HEIGHT, pick_height());
		end
		if (kern) begin
			if ($urandom_range(99) < 70)
				reg_write(REG_KERNEL_TOP, rand_kernel_row());
			if ($urandom_range(99) < 70)
				reg_write(REG_KERNEL_MIDDLE, rand_kernel_row());
			if ($urandom_range(99) < 70)
				reg_write(REG_KERNEL_BOTTOM, rand_kernel_row());
		end
	endtask

	task automatic wide_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		wait_idle();
		reg_write(REG_FRAME_WIDTH, w);
		reg_write(REG_FRAME_HEIGHT, h);
		reg_write(REG_KERNEL_MIDDLE, rand_kernel_row());
		image_frame(1'b0);
		wait_idle();
		reg_write(REG_FRAME_WIDTH, 24'd4);
		reg_write(REG_FRAME_HEIGHT, 24'd3);
	endtask

	task automatic random_frames(input int quota);
		int start;
		start = steps_taken;
		while (steps_taken - start < quota) begin
			retune_between_frames();
			image_frame($urandom_range(99) < 20);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pixels.size() == 0) begin
				report_mismatch("unexpected output", '0);
			end else begin
				head = pending_pixels.pop_front();
				if (m_axis_tdata !== head.pixel || m_axis_tlast !== head.frame_end)
					report_mismatch("output mismatch", head);
			end
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		kern_rows[0]   = KERN_TOP_RST;
		kern_rows[1]   = KERN_MIDDLE_RST;
		kern_rows[2]   = KERN_BOTTOM_RST;
		width_reg      = FRAME_WIDTH_RST;
		height_reg     = FRAME_HEIGHT_RST;
		frame_w        = int'(FRAME_WIDTH_RST);
		frame_h        = int'(FRAME_HEIGHT_RST);
		in_col         = 0;
		in_row         = 0;
		out_col        = 0;
		out_row        = 0;
		frame_steps    = 0;
		frame_received = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED_PLAN[i]) begin
			case (DIRECTED_PLAN[i].kind)
				ROW_WRITE: begin
					if (i == 0 || DIRECTED_PLAN[i - 1].kind != ROW_WRITE)
						wait_idle();
					reg_write(DIRECTED_PLAN[i].idx, DIRECTED_PLAN[i].val);
				end
				ROW_CHECK: send_item(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].pix, 1'b1,
					'{DIRECTED_PLAN[i].exp_pix, DIRECTED_PLAN[i].exp_end});
				default: send_item(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].pix, 1'b0, '0);
			endcase
		end

		// Width above the line store depth is capped; height at its register maximum.
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		wide_frame(24'd2047, 24'd1);
		random_frames(PHASE_ITEMS);
		send_idle_pct = 45;
		random_frames(PHASE_ITEMS);
		send_idle_pct  = 0;
		recv_stall_pct = 45;
		random_frames(PHASE_ITEMS);
		send_idle_pct  = 25;
		recv_stall_pct = 25;
		wide_frame(24'd1, 24'd4095);
		random_frames(PHASE_ITEMS);

		s_axis_tvalid <= 1'b0;
		cfg_write     <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (2 * LAT_WAIT) @(posedge clk);
		if (error_count == 0 && pending_pixels.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[conv2d_3x3_zero_pad.f]
+incdir+src
src/c2d_pkg.sv
src/c2d_line_store.sv
src/c2d_column_cell.sv
src/conv2d_3x3_zero_pad.sv
verif/conv2d_3x3_zero_pad_tb.sv
